/* rtl/vertex_attribute_decoder_macros.svh */
// Assertion macros shared by the vertex attribute decoder.
`ifndef VERTEX_ATTRIBUTE_DECODER_MACROS_SVH
`define VERTEX_ATTRIBUTE_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VAD_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("vertex attribute decoder check failed");

// Next-cycle implication, checked outside reset.
`define VAD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("vertex attribute decoder check failed");

`endif

/* rtl/vad_pkg.sv */
// Types and constants shared by the vertex attribute decoder modules.
package vad_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WEIGHT_FORMAT   = 3'd0;
    localparam logic [2:0] CFG_WEIGHT_COUNT    = 3'd1;
    localparam logic [2:0] CFG_TEXCOORD_FORMAT = 3'd2;
    localparam logic [2:0] CFG_COLOR_FORMAT    = 3'd3;
    localparam logic [2:0] CFG_NORMAL_FORMAT   = 3'd4;
    localparam logic [2:0] CFG_POSITION_FORMAT = 3'd5;
    localparam logic [2:0] CFG_VERTEX_SIZE     = 3'd6;

    // Format codes.
    localparam logic [1:0] WF_NONE   = 2'd0;
    localparam logic [1:0] WF_UINT8  = 2'd1;
    localparam logic [1:0] FMT_NONE  = 2'd0;
    localparam logic [1:0] FMT_NORM8 = 2'd1;
    localparam logic [1:0] FMT_NORM16 = 2'd2;
    localparam logic [1:0] FMT_FLOAT = 2'd3;
    localparam logic [2:0] CF_NONE   = 3'd0;
    localparam logic [2:0] CF_565    = 3'd4;
    localparam logic [2:0] CF_5551   = 3'd5;
    localparam logic [2:0] CF_4444   = 3'd6;
    localparam logic [2:0] CF_8888   = 3'd7;
    localparam logic [1:0] NF_NONE   = 2'd0;
    localparam logic [1:0] NF_SHORT  = 2'd1;
    localparam logic [1:0] NF_MID    = 2'd2;

    // Attribute kinds on the result side.
    localparam logic [1:0] KIND_WEIGHT   = 2'd0;
    localparam logic [1:0] KIND_TEXCOORD = 2'd1;
    localparam logic [1:0] KIND_COLOR    = 2'd2;
    localparam logic [1:0] KIND_POSITION = 2'd3;

    // Queue depths.
    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    typedef enum logic [3:0] {
        DEC_UNORM8,
        DEC_NORM8,
        DEC_NORM16,
        DEC_FLOAT,
        DEC_C565,
        DEC_C5551,
        DEC_C4444,
        DEC_DIV127,
        DEC_DIV255,
        DEC_ERROR
    } dec_t;

    typedef struct packed {
        logic [1:0] weight_format;
        logic [2:0] weight_count_less_one;
        logic [1:0] texcoord_format;
        logic [2:0] color_format;
        logic [1:0] normal_format;
        logic [1:0] position_format;
        logic [7:0] vertex_size;
    } cfg_t;

    // One decode job: a finished element plus the range of results it yields.
    typedef struct packed {
        dec_t        dec;
        logic [1:0]  kind;
        logic [2:0]  idx;
        logic [2:0]  last_idx;
        logic [31:0] raw;
        logic        vend;
    } job_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  idx;
        logic [31:0] value;
        logic        vend;
        logic        err;
    } res_t;

endpackage

/* rtl/vad_fifo.sv */
// Small register queue used between the decoder stages.
module vad_fifo
    import vad_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill level updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/vad_front.sv */
// Front end: tracks the byte position in the vertex and classifies each byte.
module vad_front
    import vad_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic [7:0] data_byte,
    output logic       job_push,
    output job_t       job
);

    logic [7:0]  offset_reg, offset_next;
    logic [23:0] partial_reg, partial_next;

    logic [8:0]  stride;
    logic [7:0]  wt_n, tex_start, col_start, pos_start, after_tex, after_col, after_nrm;
    logic [7:0]  end_off;
    logic [1:0]  tex_lg, pos_lg;
    logic        bad;
    logic [31:0] raw4;
    logic [31:0] raw2;
    logic [31:0] raw1;

    // Returns {hit, index} for a run of count elements of 2^lg bytes from start.
    function automatic logic [3:0] region(input logic [7:0] p, input logic [7:0] start,
                                          input logic [1:0] lg, input logic [1:0] count);
        logic [8:0] rel;
        logic [4:0] span;
        logic [3:0] mask;
        logic       hit;
        logic [2:0] idx;
        rel  = {1'b0, p} - {1'b0, start};
        span = 5'(count) << lg;
        mask = (4'd1 << lg) - 4'd1;
        hit  = !rel[8] && (rel < {4'd0, span}) && ((rel[3:0] & mask) == mask);
        idx  = 3'(rel >> lg);
        return {hit, idx};
    endfunction

    function automatic logic [7:0] align2(input logic [7:0] x);
        return (x + 8'd1) & 8'hFE;
    endfunction

    function automatic logic [7:0] align4(input logic [7:0] x);
        return (x + 8'd3) & 8'hFC;
    endfunction

    // Layout of the vertex from the current configuration.
    always_comb
    begin
        stride = (cfg.vertex_size == 8'd0) ? 9'd256 : {1'b0, cfg.vertex_size};
        wt_n   = (cfg.weight_format == WF_UINT8) ? {5'd0, cfg.weight_count_less_one} + 8'd1
                                                 : 8'd0;
        case (cfg.texcoord_format)
            FMT_NORM16: begin tex_start = align2(wt_n); tex_lg = 2'd1; end
            FMT_FLOAT:  begin tex_start = align4(wt_n); tex_lg = 2'd2; end
            default:    begin tex_start = wt_n;         tex_lg = 2'd0; end
        endcase
        after_tex = (cfg.texcoord_format == FMT_NONE) ? wt_n
                                                      : tex_start + (8'd2 << tex_lg);
        case (cfg.color_format)
            CF_565, CF_5551, CF_4444:
            begin
                col_start = align2(after_tex);
                after_col = col_start + 8'd2;
            end
            CF_8888:
            begin
                col_start = align4(after_tex);
                after_col = col_start + 8'd4;
            end
            default:
            begin
                col_start = after_tex;
                after_col = after_tex;
            end
        endcase
        case (cfg.normal_format)
            NF_NONE:  after_nrm = after_col;
            NF_SHORT: after_nrm = after_col + 8'd3;
            NF_MID:   after_nrm = after_col + 8'd6;
            default:  after_nrm = after_col + 8'd12;
        endcase
        case (cfg.position_format)
            FMT_NORM16: begin pos_start = align2(after_nrm); pos_lg = 2'd1; end
            FMT_FLOAT:  begin pos_start = align4(after_nrm); pos_lg = 2'd2; end
            default:    begin pos_start = after_nrm;         pos_lg = 2'd0; end
        endcase
        end_off = pos_start + (8'd3 << pos_lg);
        bad = (cfg.weight_format != WF_NONE && cfg.weight_format != WF_UINT8)
           || (cfg.color_format != CF_NONE && cfg.color_format < CF_565)
           || (cfg.position_format == FMT_NONE)
           || ({1'b0, end_off} > stride);
    end

    // Raw element words, little endian.
    assign raw4 = {data_byte, partial_reg[7:0], partial_reg[15:8], partial_reg[23:16]};
    assign raw2 = {16'd0, data_byte, partial_reg[7:0]};
    assign raw1 = {24'd0, data_byte};

    // Find the element, if any, that this byte completes.
    always_comb
    begin
        logic [3:0] tr;
        logic [3:0] pr;
        tr = region(offset_reg, tex_start, tex_lg, 2'd2);
        pr = region(offset_reg, pos_start, pos_lg, 2'd3);
        job_push     = 1'b0;
        job.dec      = DEC_ERROR;
        job.kind     = KIND_WEIGHT;
        job.idx      = 3'd0;
        job.last_idx = 3'd0;
        job.raw      = raw1;
        job.vend     = 1'b0;
        if (bad)
        begin
            job_push = accept && (offset_reg == 8'd0);
        end
        else if (cfg.weight_format == WF_UINT8 && offset_reg < wt_n)
        begin
            job_push     = accept;
            job.dec      = DEC_UNORM8;
            job.idx      = offset_reg[2:0];
            job.last_idx = (offset_reg[2:0] == cfg.weight_count_less_one) ? 3'd7
                                                                          : offset_reg[2:0];
        end
        else if (cfg.texcoord_format != FMT_NONE && tr[3])
        begin
            job_push     = accept;
            job.kind     = KIND_TEXCOORD;
            job.idx      = tr[2:0];
            job.last_idx = tr[2:0];
            case (cfg.texcoord_format)
                FMT_NORM8:  job.dec = DEC_NORM8;
                FMT_NORM16: begin job.dec = DEC_NORM16; job.raw = raw2; end
                default:    begin job.dec = DEC_FLOAT;  job.raw = raw4; end
            endcase
        end
        else if ((cfg.color_format == CF_565 || cfg.color_format == CF_5551
                  || cfg.color_format == CF_4444) && offset_reg == col_start + 8'd1)
        begin
            job_push     = accept;
            job.kind     = KIND_COLOR;
            job.last_idx = 3'd3;
            job.raw      = raw2;
            case (cfg.color_format)
                CF_565:  job.dec = DEC_C565;
                CF_5551: job.dec = DEC_C5551;
                default: job.dec = DEC_C4444;
            endcase
        end
        else if (cfg.color_format == CF_8888 && offset_reg >= col_start
                 && offset_reg < col_start + 8'd4)
        begin
            job_push     = accept;
            job.kind     = KIND_COLOR;
            job.idx      = 3'(offset_reg - col_start);
            job.last_idx = job.idx;
            job.dec      = (job.idx == 3'd3) ? DEC_DIV255 : DEC_DIV127;
        end
        else if (pr[3])
        begin
            job_push     = accept;
            job.kind     = KIND_POSITION;
            job.idx      = pr[2:0];
            job.last_idx = pr[2:0];
            job.vend     = (pr[2:0] == 3'd2);
            case (cfg.position_format)
                FMT_NORM8:  job.dec = DEC_NORM8;
                FMT_NORM16: begin job.dec = DEC_NORM16; job.raw = raw2; end
                default:    begin job.dec = DEC_FLOAT;  job.raw = raw4; end
            endcase
        end
    end

    // Byte position and history of the last three bytes.
    always_comb
    begin
        offset_next  = offset_reg;
        partial_next = partial_reg;
        if (accept)
        begin
            partial_next = {partial_reg[15:0], data_byte};
            offset_next  = ({1'b0, offset_reg} + 9'd1 >= stride) ? 8'd0 : offset_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            partial_reg <= '0;
        end
        else
        begin
            offset_reg  <= offset_next;
            partial_reg <= partial_next;
        end
    end

endmodule

/* rtl/vad_back.sv */
// Back end: expands each job into result beats and converts them to fixed point.
module vad_back
    import vad_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    input  job_t job,
    output logic job_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    typedef logic [31:0] tab_t [256];

    localparam int SEL_UNORM = 0;
    localparam int SEL_NORM8 = 1;
    localparam int SEL_D127  = 2;
    localparam int SEL_D255  = 3;
    localparam int SEL_C31   = 4;
    localparam int SEL_C63   = 5;
    localparam int SEL_C15   = 6;

    // Rounded quotient, ties away from zero, saturated to 32 bits.
    function automatic logic [31:0] qround(input longint num, input int sel);
        longint mag;
        longint q;
        logic   neg;
        neg = (num < 0);
        mag = neg ? -num : num;
        mag = mag << FRAC_BITS;
        case (sel)
            SEL_UNORM, SEL_NORM8: q = (mag + 127) / 254;
            SEL_D127:             q = (mag + 63) / 127;
            SEL_D255:             q = (mag + 127) / 255;
            SEL_C31:              q = (mag + 15) / 31;
            SEL_C63:              q = (mag + 31) / 63;
            default:              q = (mag + 7) / 15;
        endcase
        if (neg)
        begin
            q = (q >= 64'sh80000000) ? -64'sh80000000 : -q;
        end
        else if (q > 64'sh7FFFFFFF)
        begin
            q = 64'sh7FFFFFFF;
        end
        return q[31:0];
    endfunction

    function automatic tab_t build_tab(input int sel);
        tab_t   t;
        longint v;
        for (int i = 0; i < 256; i++)
        begin
            v = i;
            case (sel)
                SEL_NORM8:                  v = 2 * ((i >= 128) ? i - 256 : i) + 1;
                SEL_C31, SEL_C63, SEL_C15:  v = i * 255;
                default:                    v = i;
            endcase
            t[i] = qround(v, sel);
        end
        return t;
    endfunction

    localparam tab_t T_UNORM = build_tab(SEL_UNORM);
    localparam tab_t T_NORM8 = build_tab(SEL_NORM8);
    localparam tab_t T_D127  = build_tab(SEL_D127);
    localparam tab_t T_D255  = build_tab(SEL_D255);
    localparam tab_t T_C31   = build_tab(SEL_C31);
    localparam tab_t T_C63   = build_tab(SEL_C63);
    localparam tab_t T_C15   = build_tab(SEL_C15);
    localparam longint ALPHA_WIDE = 64'sd255 << FRAC_BITS;
    localparam logic [31:0] ALPHA_FULL = (ALPHA_WIDE > 64'sh7FFFFFFF) ? 32'h7FFFFFFF
                                                                      : ALPHA_WIDE[31:0];

    logic [2:0]  off_reg, off_next;
    logic [2:0]  cur;
    logic        fire;
    logic [31:0] norm16_val;
    logic [31:0] float_val;
    logic [31:0] value;

    // Magnitude to signed 32 bits with saturation.
    function automatic logic [31:0] sat_mag(input logic neg, input logic [55:0] mag);
        logic [31:0] r;
        if (mag >= 56'h80000000)
        begin
            r = neg ? 32'h80000000 : 32'h7FFFFFFF;
        end
        else
        begin
            r = neg ? -mag[31:0] : mag[31:0];
        end
        return r;
    endfunction

    assign cur  = job.idx + off_reg;
    assign fire = job_valid && !res_full;

    // Signed 16-bit normalization: (2v+1)/65534 via digits of 2^15-1.
    always_comb
    begin
        logic signed [17:0] n;
        logic [15:0] mag;
        logic [44:0] y;
        logic [14:0] d0, d1, d2;
        logic [16:0] s;
        logic [1:0]  c;
        logic [30:0] q;
        n   = 18'(signed'(job.raw[15:0])) * 18'sd2 + 18'sd1;
        mag = n[17] ? 16'(-n) : n[15:0];
        y   = ({29'd0, mag} << (FRAC_BITS - 1)) + 45'd16383;
        d0  = y[14:0];
        d1  = y[29:15];
        d2  = y[44:30];
        s   = {2'd0, d0} + {2'd0, d1} + {2'd0, d2};
        c   = (s >= 17'd65534) ? 2'd2 : (s >= 17'd32767) ? 2'd1 : 2'd0;
        q   = ({1'b0, d2, 15'd0}) + {16'd0, d2} + {16'd0, d1} + {29'd0, c};
        norm16_val = n[17] ? -{1'b0, q} : {1'b0, q};
    end

    // IEEE single to fixed point with rounding and saturation.
    always_comb
    begin
        logic        fneg;
        logic [7:0]  fe;
        logic [23:0] fm;
        logic signed [9:0] sh;
        logic [4:0]  rs;
        logic [55:0] mag;
        fneg = job.raw[31];
        fe   = job.raw[30:23];
        fm   = {(fe != 8'd0), job.raw[22:0]};
        sh   = signed'({2'd0, (fe == 8'd0) ? 8'd1 : fe}) + 10'(FRAC_BITS) - 10'sd150;
        rs   = 5'(-sh);
        mag  = '0;
        if (fe == 8'hFF)
        begin
            float_val = (job.raw[22:0] != '0) ? 32'd0 : sat_mag(fneg, '1);
        end
        else if (fm == '0)
        begin
            float_val = 32'd0;
        end
        else if (sh >= 10'sd32)
        begin
            float_val = sat_mag(fneg, '1);
        end
        else if (sh >= 10'sd0)
        begin
            mag       = {32'd0, fm} << sh[4:0];
            float_val = sat_mag(fneg, mag);
        end
        else if (sh <= -10'sd26)
        begin
            float_val = 32'd0;
        end
        else
        begin
            mag       = (({32'd0, fm} >> (rs - 5'd1)) + 56'd1) >> 1;
            float_val = sat_mag(fneg, mag);
        end
    end

    // Value of the current beat.
    always_comb
    begin
        unique case (job.dec)
            DEC_UNORM8: value = (cur == job.idx) ? T_UNORM[job.raw[7:0]] : 32'd0;
            DEC_NORM8:  value = T_NORM8[job.raw[7:0]];
            DEC_NORM16: value = norm16_val;
            DEC_FLOAT:  value = float_val;
            DEC_DIV127: value = T_D127[job.raw[7:0]];
            DEC_DIV255: value = T_D255[job.raw[7:0]];
            DEC_C565:
            begin
                case (cur[1:0])
                    2'd0:    value = T_C31[{3'd0, job.raw[15:11]}];
                    2'd1:    value = T_C63[{2'd0, job.raw[10:5]}];
                    2'd2:    value = T_C31[{3'd0, job.raw[4:0]}];
                    default: value = ALPHA_FULL;
                endcase
            end
            DEC_C5551:
            begin
                case (cur[1:0])
                    2'd0:    value = T_C31[{3'd0, job.raw[15:11]}];
                    2'd1:    value = T_C31[{3'd0, job.raw[10:6]}];
                    2'd2:    value = T_C31[{3'd0, job.raw[5:1]}];
                    default: value = job.raw[15] ? ALPHA_FULL : 32'd0;
                endcase
            end
            DEC_C4444:
            begin
                case (cur[1:0])
                    2'd0:    value = T_C15[{4'd0, job.raw[15:12]}];
                    2'd1:    value = T_C15[{4'd0, job.raw[11:8]}];
                    2'd2:    value = T_C15[{4'd0, job.raw[7:4]}];
                    default: value = T_C15[{4'd0, job.raw[3:0]}];
                endcase
            end
            default:    value = 32'd0;
        endcase
    end

    assign res_push   = fire;
    assign job_pop    = fire && (cur == job.last_idx);
    assign res.kind   = job.kind;
    assign res.idx    = cur;
    assign res.value  = value;
    assign res.vend   = job.vend;
    assign res.err    = (job.dec == DEC_ERROR);

    // Beat counter within the current job.
    always_comb
    begin
        off_next = off_reg;
        if (fire)
        begin
            off_next = job_pop ? 3'd0 : off_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
        end
        else
        begin
            off_reg <= off_next;
        end
    end

endmodule

/* rtl/vertex_attribute_decoder.sv */
// Top level of the vertex attribute decoder: configuration, job and result queues.
// Usage:
// - Input channel: one vertex byte per beat, taken when push is high and full is low.
// - Result channel: the oldest result sits on the result ports while empty is low and
//   leaves when pop is high. format_error marks the single result that each vertex of a bad layout yields.
// - Configuration channel: cfg_ready is always high; cfg_index selects the register.
//   Write only while no byte is in flight and the result queue has drained.
// - Path: a byte that completes an element is written into the job queue when it is taken;
//   the fixed-point conversion then turns the job at the head of that queue into results
//   pushed into the result queue, whose head drives the result ports.
// - Throughput: one byte per cycle in; one result beat per cycle out from the
//   conversion unit while the result queue has room. A byte that yields several results
//   (colour packs, padded weights) holds the conversion unit until its last result beat
//   is pushed, and the input stalls once the four-entry job queue fills.
// - When the receiver stalls, the four-entry result queue fills, then the job queue,
//   then full rises; nothing is dropped.
// - Reset clears the byte position, the byte history, both queues and the registers
//   to their defaults (normalized 8-bit positions, stride of one byte).
`include "vertex_attribute_decoder_macros.svh"
module vertex_attribute_decoder
    import vad_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         data_byte,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         attr_kind,
    output logic [2:0]         element_index,
    output logic signed [31:0] value,
    output logic               vertex_end,
    output logic               format_error,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic accept;
    logic jq_push, jq_full, jq_empty, jq_pop;
    job_t jq_in, jq_head;
    logic [$bits(job_t)-1:0] jq_rdata;
    logic rq_push, rq_full;
    res_t rq_in, rq_head;
    logic [$bits(res_t)-1:0] rq_rdata;

    assign cfg_ready = 1'b1;
    assign accept    = push && !jq_full;
    assign full      = jq_full;

    // Configuration registers.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WEIGHT_FORMAT:   cfg_next.weight_format         = cfg_data[1:0];
                CFG_WEIGHT_COUNT:    cfg_next.weight_count_less_one = cfg_data[2:0];
                CFG_TEXCOORD_FORMAT: cfg_next.texcoord_format       = cfg_data[1:0];
                CFG_COLOR_FORMAT:    cfg_next.color_format          = cfg_data[2:0];
                CFG_NORMAL_FORMAT:   cfg_next.normal_format         = cfg_data[1:0];
                CFG_POSITION_FORMAT: cfg_next.position_format       = cfg_data[1:0];
                CFG_VERTEX_SIZE:     cfg_next.vertex_size           = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{weight_format:         WF_NONE,
                         weight_count_less_one: 3'd0,
                         texcoord_format:       FMT_NONE,
                         color_format:          CF_NONE,
                         normal_format:         NF_NONE,
                         position_format:       FMT_NORM8,
                         vertex_size:           8'd1};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Byte classification.
    vad_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .data_byte (data_byte),
        .job_push  (jq_push),
        .job       (jq_in)
    );

    // Jobs waiting for conversion.
    vad_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (jq_push),
        .push_data (jq_in),
        .full      (jq_full),
        .pop       (jq_pop),
        .pop_data  (jq_rdata),
        .empty     (jq_empty)
    );

    assign jq_head = job_t'(jq_rdata);

    // Conversion to fixed point.
    vad_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!jq_empty),
        .job       (jq_head),
        .job_pop   (jq_pop),
        .res_full  (rq_full),
        .res_push  (rq_push),
        .res       (rq_in)
    );

    // Results waiting for the receiver.
    vad_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rq_push),
        .push_data (rq_in),
        .full      (rq_full),
        .pop       (pop),
        .pop_data  (rq_rdata),
        .empty     (empty)
    );

    assign rq_head       = res_t'(rq_rdata);
    assign attr_kind     = rq_head.kind;
    assign element_index = rq_head.idx;
    assign value         = signed'(rq_head.value);
    assign vertex_end    = rq_head.vend;
    assign format_error  = rq_head.err;

    // Checks on the result stream and the queue coupling.
    `VAD_ASSERT_IMP(a_err_beat_clean, clk, rst_n, !empty && format_error, value == 32'sd0 && attr_kind == KIND_WEIGHT && element_index == 3'd0 && !vertex_end)
    `VAD_ASSERT_IMP(a_vend_on_pos_z, clk, rst_n, !empty && vertex_end, attr_kind == KIND_POSITION && element_index == 3'd2)
    `VAD_ASSERT_IMP(a_no_write_when_full, clk, rst_n, rq_push, !rq_full)
    `VAD_ASSERT_NEXT(a_job_pop_leaves_room, clk, rst_n, jq_pop && !jq_push, !jq_full)

endmodule
